// ===== hw/rtl/first_match_substring_replace_unit_assert.svh =====
// assertion macros for the first-match substring replace unit
`ifndef FIRST_MATCH_SUBSTRING_REPLACE_UNIT_ASSERT_SVH
`define FIRST_MATCH_SUBSTRING_REPLACE_UNIT_ASSERT_SVH

// same-cycle implication
`define FMSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fmsr_pkg.sv =====
// shared constants and types of the first-match substring replace unit
`default_nettype none

package fmsr_pkg;

  localparam int BYTE_W              = 8;
  localparam int LEN_W               = 4;
  localparam int CFG_IDX_W           = 4;
  localparam int CFG_DATA_W          = 64;
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 4'd0,
    REG_PATTERN_LENGTH     = 4'd1,
    REG_REPLACEMENT_BYTES  = 4'd2,
    REG_REPLACEMENT_LENGTH = 4'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fmsr_text_if.sv =====
// input text channel
`default_nettype none

interface fmsr_text_if;
  import fmsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fmsr_result_if.sv =====
// edited text result channel
`default_nettype none

interface fmsr_result_if;
  import fmsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              out_last;
  logic              was_replaced;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output was_replaced, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  input was_replaced, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fmsr_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface fmsr_cfg_if;
  import fmsr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/first_match_substring_replace_unit.sv =====
// top level of the first-match substring replace unit
`default_nettype none

// Streams text one byte per transfer and replaces the first occurrence of the
// configured pattern (1 to MAX_PATTERN bytes) by the configured replacement
// (0 to MAX_REPLACEMENT bytes); the rest of the text passes unchanged and the
// final result flags whether a replacement happened. An accepted byte waits in
// a one-entry input register; the window compare moves its results into an
// output buffer that drains one result per cycle while result.ready is high.
// A byte that yields zero or one result frees the unit for the next byte, so
// the sustained rate is one byte per cycle when results are taken; a byte that
// yields n results (a match with an n-byte replacement, or the end-of-text
// flush of n held bytes) holds off the next byte until those results drain.
// Configuration is taken at any time without stall; a write to a mapped register restarts the text.

module first_match_substring_replace_unit #(
  parameter int MAX_PATTERN     = fmsr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = fmsr_pkg::DEF_MAX_REPLACEMENT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  fmsr_text_if.sink     text,
  fmsr_result_if.source result,
  fmsr_cfg_if.sink      cfg
);
  import fmsr_pkg::*;

`include "first_match_substring_replace_unit_assert.svh"

  localparam int BUF_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int WIN_IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [LEN_W-1:0]      rep_len;

  // stream state
  logic [BYTE_W-1:0] win [MAX_PATTERN];
  logic [BYTE_W-1:0] win_next [MAX_PATTERN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              done;
  logic              done_next;

  // input register
  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_last;

  // output buffer
  logic [BYTE_W-1:0] obuf [BUF_DEPTH];
  logic [CNT_W-1:0]  count;
  logic              obuf_last;
  logic              obuf_repl;
  logic              obuf_marker;

  // buffer load
  logic [BYTE_W-1:0] load_bytes [BUF_DEPTH];
  logic [CNT_W-1:0]  load_count;
  logic              load_last;
  logic              load_repl;
  logic              load_marker;

  logic [LEN_W-1:0]  plen_clip;
  logic [LEN_W-1:0]  rlen_eff;
  logic [FILL_W-1:0] plen_eff;
  logic [FILL_W-1:0] slot;
  logic [FILL_W-1:0] fill_upd;
  logic [BYTE_W-1:0] win_upd [MAX_PATTERN];
  logic              hit;

  logic cfg_write;
  logic text_xfer;
  logic pop;
  logic move;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  assign pop       = result.valid && result.ready;
  assign move      = hold_valid && ((count == '0) || ((count == CNT_W'(1)) && result.ready));
  assign text.ready = !hold_valid || move;
  assign text_xfer = text.valid && text.ready;

  assign result.valid        = (count != '0);
  assign result.out_byte     = obuf_marker ? '0 : obuf[0];
  assign result.byte_valid   = !obuf_marker;
  assign result.out_last     = obuf_last && (count == CNT_W'(1));
  assign result.was_replaced = obuf_repl && (count == CNT_W'(1));

  assign plen_clip = (pat_len == '0) ? LEN_W'(1) :
                     (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;
  assign plen_eff  = plen_clip[FILL_W-1:0];
  assign rlen_eff  = (rep_len > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rep_len;

  always_comb begin
    win_next    = win;
    win_upd     = win;
    fill_next   = fill;
    done_next   = done;
    slot        = '0;
    fill_upd    = '0;
    hit         = 1'b0;
    load_count  = '0;
    load_last   = 1'b0;
    load_repl   = 1'b0;
    load_marker = 1'b0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      load_bytes[i] = '0;
    end
    if (done) begin
      load_bytes[0] = hold_byte;
      load_count    = CNT_W'(1);
      load_last     = hold_last;
      load_repl     = hold_last;
      if (hold_last) begin
        done_next = 1'b0;
      end
    end else begin
      slot = (fill >= plen_eff) ? (plen_eff - FILL_W'(1)) : fill;
      win_upd[slot[WIN_IW-1:0]] = hold_byte;
      fill_upd = slot + FILL_W'(1);
      hit = (fill_upd == plen_eff);
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if ((i < int'(plen_eff)) && (win_upd[i] != pat_bytes[BYTE_W*i +: BYTE_W])) begin
          hit = 1'b0;
        end
      end
      win_next = win_upd;
      if (hit) begin
        // replacement, or an empty end marker when it is empty at end of text
        if (hold_last && (rlen_eff == '0)) begin
          load_count  = CNT_W'(1);
          load_marker = 1'b1;
        end else begin
          for (int i = 0; i < MAX_REPLACEMENT; i++) begin
            load_bytes[i] = rep_bytes[BYTE_W*i +: BYTE_W];
          end
          load_count = rlen_eff[CNT_W-1:0];
        end
        load_last = hold_last;
        load_repl = hold_last;
        fill_next = '0;
        done_next = !hold_last;
      end else if (hold_last) begin
        // end of text flush
        for (int i = 0; i < MAX_PATTERN; i++) begin
          load_bytes[i] = win_upd[i];
        end
        load_count = CNT_W'(fill_upd);
        load_last  = 1'b1;
        fill_next  = '0;
      end else if (fill_upd == plen_eff) begin
        load_bytes[0] = win_upd[0];
        load_count    = CNT_W'(1);
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win_next[i] = win_upd[i+1];
        end
        fill_next = fill_upd - FILL_W'(1);
      end else begin
        fill_next = fill_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= LEN_W'(1);
      rep_bytes <= '0;
      rep_len   <= '0;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_PATTERN_BYTES:      pat_bytes <= cfg.data;
        REG_PATTERN_LENGTH:     pat_len   <= cfg.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes <= cfg.data;
        REG_REPLACEMENT_LENGTH: rep_len   <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= '0;
      end
    end else if (cfg_write && (cfg.index <= REG_REPLACEMENT_LENGTH)) begin
      fill <= '0;
      done <= 1'b0;
    end else if (move) begin
      fill <= fill_next;
      done <= done_next;
      win  <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_xfer) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_xfer) begin
      hold_byte <= text.text_byte;
      hold_last <= text.text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (move) begin
      count <= load_count;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      obuf        <= load_bytes;
      obuf_last   <= load_last;
      obuf_repl   <= load_repl;
      obuf_marker <= load_marker;
    end else if (pop) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

  `FMSR_ASSERT_NOW(a_done_window_empty, done, fill == '0, "window holds bytes after the replacement")
  `FMSR_ASSERT_NOW(a_load_when_drained, move, (count == '0) || ((count == CNT_W'(1)) && result.ready), "output buffer overwritten before drained")
  `FMSR_ASSERT_NEXT(a_hold_kept, hold_valid && !move, hold_valid && $stable(hold_byte) && $stable(hold_last), "held byte lost while stalled")

endmodule

`default_nettype wire

// ===== tb/fmsr_edit_compare.sv =====
// predicts the edited text from observed transfers and compares it with the result channel
module fmsr_edit_compare (
  input  wire logic clk,
  input  wire logic rst,
  fmsr_text_if      text_ch,
  fmsr_result_if    result_ch,
  fmsr_cfg_if       cfg_ch,
  output int        error_count,
  output int        pending_count,
  output int        checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fmsr_pkg::*;

  localparam int MAX_PAT = DEF_MAX_PATTERN;
  localparam int MAX_REP = DEF_MAX_REPLACEMENT;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              out_last;
    logic              was_replaced;
  } edit_res_t;

  edit_res_t             expected_q[$];
  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [LEN_W-1:0]      rep_len;
  logic [BYTE_W-1:0]     win [MAX_PAT];
  int                    win_fill;
  bit                    repl_done;

  task automatic edit_byte(input logic [BYTE_W-1:0] b, input logic last);
    int   plen;
    int   rlen;
    bit   hit;
    logic fin;
    plen = (pat_len == 0) ? 1 : (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    rlen = (rep_len > MAX_REP) ? MAX_REP : int'(rep_len);
    if (repl_done) begin
      expected_q.push_back('{b, 1'b1, last, last});
      if (last) begin
        win_fill  = 0;
        repl_done = 1'b0;
      end
      return;
    end
    if (win_fill >= plen) win_fill = plen - 1;
    win[win_fill] = b;
    win_fill++;
    hit = (win_fill == plen);
    for (int i = 0; i < plen; i++) begin
      if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      for (int i = 0; i < rlen; i++) begin
        fin = last && (i == rlen - 1);
        expected_q.push_back('{rep_bytes[8*i +: 8], 1'b1, fin, fin});
      end
      // empty replacement at end of text still closes the text
      if (last && rlen == 0) expected_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      win_fill  = 0;
      repl_done = !last;
    end else if (last) begin
      for (int i = 0; i < win_fill; i++) begin
        expected_q.push_back('{win[i], 1'b1, (i == win_fill - 1), 1'b0});
      end
      win_fill  = 0;
      repl_done = 1'b0;
    end else if (win_fill == plen) begin
      expected_q.push_back('{win[0], 1'b1, 1'b0, 1'b0});
      for (int i = 1; i < plen; i++) win[i-1] = win[i];
      win_fill--;
    end
  endtask

  always @(posedge clk) begin
    edit_res_t got;
    edit_res_t want;
    if (rst) begin
      expected_q.delete();
      pat_bytes     = '0;
      pat_len       = 4'd1;
      rep_bytes     = '0;
      rep_len       = '0;
      win_fill      = 0;
      repl_done     = 1'b0;
      error_count   = 0;
      checked_count = 0;
      for (int i = 0; i < MAX_PAT; i++) win[i] = '0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.out_byte, result_ch.byte_valid, result_ch.out_last,
                result_ch.was_replaced};
        if (expected_q.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result: byte %02h valid %b last %b replaced %b",
                     got.out_byte, got.byte_valid, got.out_last, got.was_replaced);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (error_count < 10)
              $display({"result %0d: expected byte %02h valid %b last %b replaced %b,",
                        " got byte %02h valid %b last %b replaced %b"}, checked_count,
                       want.out_byte, want.byte_valid, want.out_last, want.was_replaced,
                       got.out_byte, got.byte_valid, got.out_last, got.was_replaced);
            error_count++;
          end
        end
        checked_count++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PATTERN_BYTES:      pat_bytes = cfg_ch.data;
          REG_PATTERN_LENGTH:     pat_len   = cfg_ch.data[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  rep_bytes = cfg_ch.data;
          REG_REPLACEMENT_LENGTH: rep_len   = cfg_ch.data[LEN_W-1:0];
          default: ;
        endcase
        // unmapped index leaves the text in progress alone
        if (cfg_ch.index <= REG_REPLACEMENT_LENGTH) begin
          win_fill  = 0;
          repl_done = 1'b0;
        end
      end
      if (text_ch.valid && text_ch.ready) edit_byte(text_ch.text_byte, text_ch.text_last);
    end
    pending_count = expected_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus, clock, reset and verdict for the first-match substring replace unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fmsr_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 430;
  localparam int TAIL_QUIET    = 60;
  localparam int MAX_PAT       = DEF_MAX_PATTERN;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP = {CFG_IDX_W{1'b1}};

  typedef logic [BYTE_W-1:0] byte_q_t [$];
  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_wr_t;

  logic clk;
  logic rst;
  int   error_count;
  int   pending_count;
  int   checked_count;
  int   cycle_count;
  int   bytes_sent;
  int   texts_sent;
  int   writes_done;
  bit   idle_on;
  bit   hold_request;

  reg_wr_t               reg_wr_q[$];
  logic [CFG_DATA_W-1:0] cur_pat;
  int                    cur_plen;

  fmsr_text_if   text_ch();
  fmsr_result_if result_ch();
  fmsr_cfg_if    cfg_ch();

  first_match_substring_replace_unit dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  fmsr_edit_compare edit_cmp (
    .clk           (clk),
    .rst           (rst),
    .text_ch       (text_ch),
    .result_ch     (result_ch),
    .cfg_ch        (cfg_ch),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin : result_ready_gen
    int n;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // leaves valid high after the transfer so back-to-back bytes go without a gap
  task automatic send_text(input logic [BYTE_W-1:0] b, input logic last);
    int n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      text_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.text_last <= last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_string(input byte_q_t s, input bit terminate);
    foreach (s[i]) send_text(s[i], terminate && (i == s.size() - 1));
    if (terminate) texts_sent++;
  endtask

  // stop the text and wait until every expected result has been taken
  task automatic settle();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    foreach (reg_wr_q[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_wr_q[i].idx;
      cfg_ch.data  <= reg_wr_q[i].data;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      writes_done++;
    end
    cfg_ch.valid <= 1'b0;
    reg_wr_q.delete();
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
                               input logic [CFG_DATA_W-1:0] rep, input logic [LEN_W-1:0] rlen);
    logic [CFG_DATA_W-1:0] junk_p;
    logic [CFG_DATA_W-1:0] junk_r;
    // length registers sometimes carry noise above the used bits
    junk_p = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : '0;
    junk_r = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : '0;
    settle();
    reg_wr_q.push_back('{REG_PATTERN_BYTES, pat});
    reg_wr_q.push_back('{REG_PATTERN_LENGTH, {junk_p[CFG_DATA_W-1:LEN_W], plen}});
    reg_wr_q.push_back('{REG_REPLACEMENT_BYTES, rep});
    reg_wr_q.push_back('{REG_REPLACEMENT_LENGTH, {junk_r[CFG_DATA_W-1:LEN_W], rlen}});
    write_regs();
    cur_pat  = pat;
    cur_plen = (plen == 0) ? 1 : (plen > MAX_PAT) ? MAX_PAT : int'(plen);
  endtask

  initial begin : stimulus
    byte_q_t              s;
    logic [BYTE_W-1:0]    c;
    logic [CFG_DATA_W-1:0] pat;
    logic [LEN_W-1:0]     plen;
    logic [LEN_W-1:0]     rlen;
    int                   len;
    int                   pos;
    int                   sel;
    int                   ntexts;
    int                   random_end;
    bit                   noisy;
    bit                   hold_fired;
    bit                   drain_fired;

    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.text_last <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_PATTERN_BYTES;
    cfg_ch.data       <= '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    hold_fired   = 1'b0;
    drain_fired  = 1'b0;
    cur_pat      = '0;
    cur_plen     = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: one-byte zero pattern, empty replacement
    send_string('{8'h41, 8'h00, 8'h42}, 1'b1);
    send_string('{8'h00}, 1'b1);

    // match at the first byte, match on the last byte
    apply_setting(64'h6261, 4'd2, 64'h5a5958, 4'd3);
    send_string('{8'h61, 8'h62, 8'h63, 8'h64}, 1'b1);
    send_string('{8'h7a, 8'h61, 8'h62}, 1'b1);

    // widest pattern and replacement
    apply_setting({8{8'hff}}, 4'd8, {8{8'h01}}, 4'd8);
    send_string('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1);

    // lengths out of range are clamped
    apply_setting(64'h41, 4'd0, {$urandom(), $urandom()}, 4'hf);
    send_string('{8'h41}, 1'b1);

    // unmapped index keeps the partial window, a real write drops it
    apply_setting(64'h7a7978, 4'd3, 64'h5352, 4'd2);
    send_string('{8'h78, 8'h79}, 1'b0);
    settle();
    reg_wr_q.push_back('{CFG_IDX_W'(REG_REPLACEMENT_LENGTH + 1), {$urandom(), $urandom()}});
    write_regs();
    send_string('{8'h7a}, 1'b1);
    send_string('{8'h78, 8'h79}, 1'b0);
    settle();
    reg_wr_q.push_back('{REG_PATTERN_LENGTH, 64'd3});
    write_regs();
    send_string('{8'h7a}, 1'b1);

    random_end = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < random_end) begin
      for (int k = 0; k < MAX_PAT; k++) begin
        // a two-letter alphabet gives overlapping partial matches
        pat[8*k +: 8] = ($urandom_range(0, 1) == 1) ? BYTE_W'(8'h61 + $urandom_range(0, 1))
                                                    : BYTE_W'($urandom_range(0, 255));
      end
      plen = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? 4'd0
                                              : LEN_W'($urandom_range(9, 15)))
                                         : LEN_W'($urandom_range(1, 8));
      rlen = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                         : LEN_W'($urandom_range(0, 8));
      apply_setting(pat, plen, {$urandom(), $urandom()}, rlen);
      if ($urandom_range(0, 3) == 0) begin
        reg_wr_q.push_back('{CFG_IDX_W'($urandom_range(REG_REPLACEMENT_LENGTH + 1, IDX_TOP)),
                             {$urandom(), $urandom()}});
        write_regs();
      end
      ntexts = $urandom_range(1, 6);
      repeat (ntexts) begin
        len   = $urandom_range(1, 16);
        noisy = ($urandom_range(0, 4) == 0);
        s.delete();
        repeat (len) begin
          if (noisy) begin
            c = BYTE_W'($urandom_range(0, 255));
          end else begin
            case ($urandom_range(0, 3))
              0, 1: begin
                sel = $urandom_range(0, cur_plen - 1);
                c   = cur_pat[8*sel +: 8];
              end
              2: c = BYTE_W'(8'h61 + $urandom_range(0, 2));
              default: c = BYTE_W'($urandom_range(1, 255));
            endcase
          end
          s.push_back(c);
        end
        if (!noisy && $urandom_range(0, 2) != 0) begin
          pos = $urandom_range(0, s.size());
          for (int k = 0; k < cur_plen; k++) s.insert(pos + k, cur_pat[8*k +: 8]);
        end
        if (bytes_sent > random_end - TAIL_QUIET) idle_on = 1'b0;
        send_string(s, $urandom_range(0, 7) != 0);
        if (!hold_fired && bytes_sent > 150) begin
          hold_fired   = 1'b1;
          hold_request = 1'b1;
        end
        if (!drain_fired && bytes_sent > 280) begin
          drain_fired = 1'b1;
          settle();
        end
      end
    end

    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d text bytes in %0d closed texts, %0d register writes",
             bytes_sent, texts_sent, writes_done);
    $display("checked %0d results, %0d errors", checked_count, error_count + pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
